>>> hdl/sle_pkg.sv
// Shared constants, command codes and controller/datapath interface types for the list engine.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

    localparam int CAPACITY_DEFAULT = 32;
    localparam int DATA_W           = 32;
    localparam int POS_W            = 6;
    localparam int CMD_W            = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_MIN = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_step;
        logic load;
        logic check;
        logic read_en;
        logic fix;
        logic commit;
    } sle_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;
        logic scan_needed;
        logic fix_needed;
        logic scan_last;
    } sle_status_t;

endpackage

`default_nettype wire

>>> hdl/sequential_list_engine.sv
// Top level of the sequential list engine: controller, datapath and port checks.
//
// An ordered list of up to CAPACITY signed 32-bit words. Each beat on the s_ channel
// carries one command (insert, delete, update, locate, remove minimum) with a 1-based
// position and a value; each command yields exactly one beat on the m_ channel with
// ok, the locate position, the removed value and the list length after the command.
// The list lives in a single-port-write RAM with registered read, so commands that
// shift or search walk the entries one per cycle through that read port.
// One command is in flight at a time; s_ready returns when the result is registered.
// The result register holds while m_ready is low, and the next command is accepted
// meanwhile, but it cannot finish until the waiting result has been taken.
// After reset the RAM is filled with 1, 2, ... CAPACITY, with s_ready low,
// and the list starts full.
`timescale 1ns / 1ps
`default_nettype none

module sequential_list_engine #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [sle_pkg::CMD_W-1:0]          s_command,
    input  wire logic [sle_pkg::POS_W-1:0]          s_position,
    input  wire logic signed [sle_pkg::DATA_W-1:0]  s_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_ok,
    output logic [sle_pkg::POS_W-1:0]               m_found_position,
    output logic signed [sle_pkg::DATA_W-1:0]       m_removed_value,
    output logic [sle_pkg::POS_W-1:0]               m_list_count
);

    sle_pkg::sle_cmd_t    cmd;
    sle_pkg::sle_status_t status;

    sle_controller u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .status (status)
    );

    sle_datapath #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_command       (s_command),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_ok            (m_ok),
        .m_found_position(m_found_position),
        .m_removed_value (m_removed_value),
        .m_list_count    (m_list_count)
    );

    // Only one command is worked on at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command accepted while one is in progress");

    // A reported locate position always comes with success.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_found_position != '0) |-> m_ok)
        else $error("locate position reported on a failed command");

    // A rejected command never reports a removed value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> (m_removed_value == '0))
        else $error("removed value reported on a failed command");

endmodule

`default_nettype wire

>>> hdl/sle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/sle_datapath.sv
// List engine datapath: list length, walk pointer, scan bookkeeping, RAM and result registers.
`timescale 1ns / 1ps
`default_nettype none

module sle_datapath #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sle_pkg::sle_cmd_t             cmd,
    output sle_pkg::sle_status_t               status,
    input  wire logic [sle_pkg::CMD_W-1:0]     s_command,
    input  wire logic [sle_pkg::POS_W-1:0]     s_position,
    input  wire logic signed [sle_pkg::DATA_W-1:0] s_value,
    output logic                               m_ok,
    output logic [sle_pkg::POS_W-1:0]          m_found_position,
    output logic signed [sle_pkg::DATA_W-1:0]  m_removed_value,
    output logic [sle_pkg::POS_W-1:0]          m_list_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > sle_pkg::POS_W) ? LW : sle_pkg::POS_W) + 1;
    localparam int DW = sle_pkg::DATA_W;
    localparam int PW = sle_pkg::POS_W;

    logic [sle_pkg::CMD_W-1:0] op_reg, op_next;
    logic [PW-1:0]             pos_reg, pos_next;
    logic [DW-1:0]             val_reg, val_next;
    logic [LW-1:0]             len_reg, len_next;
    logic [AW-1:0]             ptr_reg, ptr_next;
    logic [AW-1:0]             end_reg, end_next;
    logic [AW-1:0]             q_reg, q_next;
    logic                      pv_reg, pv_next;
    logic                      first_reg, first_next;
    logic [DW-1:0]             best_reg, best_next;
    logic [AW-1:0]             at_reg, at_next;
    logic [DW-1:0]             last_reg, last_next;
    logic [DW-1:0]             removed_reg, removed_next;
    logic [LW-1:0]             found_reg, found_next;
    logic                      hit_reg, hit_next;
    logic                      ok_out_reg, ok_out_next;
    logic [PW-1:0]             found_out_reg, found_out_next;
    logic [DW-1:0]             removed_out_reg, removed_out_next;
    logic [PW-1:0]             count_out_reg, count_out_next;

    logic [CW-1:0] pos_ext, len_ext;
    logic          pos_nz, len_nz, ins_ok, at_ok;
    logic          op_ok, scan_needed, fix_needed;
    logic [AW-1:0] pos_addr, last_addr, start_addr, stop_addr;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] rd_data;

    sle_ram #(
        .WIDTH(DW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(ptr_reg),
        .rd_data(rd_data)
    );

    // Range checks on the loaded command against the current length; walk bounds and write needs.
    always_comb begin
        pos_ext   = CW'(pos_reg);
        len_ext   = CW'(len_reg);
        pos_nz    = (pos_reg != '0);
        len_nz    = (len_reg != '0);
        ins_ok    = pos_nz && (pos_ext <= len_ext + CW'(1)) && (len_ext < CW'(CAPACITY));
        at_ok     = pos_nz && (pos_ext <= len_ext);
        pos_addr  = AW'(pos_reg - PW'(1));
        last_addr = AW'(len_reg - LW'(1));

        op_ok       = 1'b0;
        scan_needed = 1'b0;
        fix_needed  = 1'b0;
        start_addr  = '0;
        stop_addr   = last_addr;
        case (op_reg)
            sle_pkg::CMD_INSERT: begin
                op_ok       = ins_ok;
                scan_needed = ins_ok && (pos_ext <= len_ext);
                fix_needed  = ins_ok;
                start_addr  = last_addr;
                stop_addr   = pos_addr;
            end
            sle_pkg::CMD_DELETE: begin
                op_ok       = at_ok;
                scan_needed = at_ok;
                start_addr  = pos_addr;
            end
            sle_pkg::CMD_UPDATE: begin
                op_ok      = at_ok;
                fix_needed = at_ok;
            end
            sle_pkg::CMD_LOCATE: begin
                op_ok       = 1'b1;
                scan_needed = len_nz;
            end
            sle_pkg::CMD_REMOVE_MIN: begin
                op_ok       = len_nz;
                scan_needed = len_nz;
                fix_needed  = len_nz;
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    assign status.init_last   = (ptr_reg == AW'(CAPACITY - 1));
    assign status.scan_needed = scan_needed;
    assign status.fix_needed  = fix_needed;
    assign status.scan_last   = (ptr_reg == end_reg);

    // RAM write port: initial fill, element moves during the walk, final write.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_data = DW'(ptr_reg) + DW'(1);
        if (cmd.init_step) begin
            wr_en = 1'b1;
        end else if (cmd.fix) begin
            wr_en = 1'b1;
            if (op_reg == sle_pkg::CMD_REMOVE_MIN) begin
                wr_addr = at_reg;
                wr_data = last_reg;
            end else begin
                wr_addr = pos_addr;
                wr_data = val_reg;
            end
        end else if (pv_reg) begin
            if (op_reg == sle_pkg::CMD_INSERT) begin
                wr_en   = 1'b1;
                wr_addr = q_reg + AW'(1);
                wr_data = rd_data;
            end else if (op_reg == sle_pkg::CMD_DELETE && !first_reg) begin
                wr_en   = 1'b1;
                wr_addr = q_reg - AW'(1);
                wr_data = rd_data;
            end
        end
    end

    always_comb begin
        op_next          = op_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        len_next         = len_reg;
        ptr_next         = ptr_reg;
        end_next         = end_reg;
        q_next           = ptr_reg;
        pv_next          = cmd.read_en;
        first_next       = first_reg;
        best_next        = best_reg;
        at_next          = at_reg;
        last_next        = last_reg;
        removed_next     = removed_reg;
        found_next       = found_reg;
        hit_next         = hit_reg;
        ok_out_next      = ok_out_reg;
        found_out_next   = found_out_reg;
        removed_out_next = removed_out_reg;
        count_out_next   = count_out_reg;

        if (cmd.init_step) begin
            ptr_next = ptr_reg + AW'(1);
        end

        if (cmd.load) begin
            op_next  = s_command;
            pos_next = s_position;
            val_next = s_value;
        end

        if (cmd.check) begin
            ptr_next   = start_addr;
            end_next   = stop_addr;
            first_next = 1'b1;
            hit_next   = 1'b0;
        end

        if (cmd.read_en) begin
            if (op_reg == sle_pkg::CMD_INSERT) begin
                ptr_next = ptr_reg - AW'(1);
            end else begin
                ptr_next = ptr_reg + AW'(1);
            end
        end

        // Read data arrives in the cycle after its address; q_reg names the entry.
        if (pv_reg) begin
            first_next = 1'b0;
            if (op_reg == sle_pkg::CMD_DELETE && first_reg) begin
                removed_next = rd_data;
            end
            if (op_reg == sle_pkg::CMD_LOCATE && !hit_reg && rd_data == val_reg) begin
                hit_next   = 1'b1;
                found_next = LW'(q_reg) + LW'(1);
            end
            if (op_reg == sle_pkg::CMD_REMOVE_MIN) begin
                if (first_reg || ($signed(rd_data) < $signed(best_reg))) begin
                    best_next = rd_data;
                    at_next   = q_reg;
                end
                if (q_reg == end_reg) begin
                    last_next = rd_data;
                end
            end
        end

        if (cmd.commit) begin
            if (op_ok) begin
                case (op_reg)
                    sle_pkg::CMD_INSERT:     len_next = len_reg + LW'(1);
                    sle_pkg::CMD_DELETE:     len_next = len_reg - LW'(1);
                    sle_pkg::CMD_REMOVE_MIN: len_next = len_reg - LW'(1);
                    default:                 len_next = len_reg;
                endcase
            end
            ok_out_next      = (op_reg == sle_pkg::CMD_LOCATE) ? hit_reg : op_ok;
            found_out_next   = (op_reg == sle_pkg::CMD_LOCATE && hit_reg) ?
                               PW'(found_reg) : '0;
            removed_out_next = '0;
            if (op_ok && op_reg == sle_pkg::CMD_DELETE) begin
                removed_out_next = removed_reg;
            end else if (op_ok && op_reg == sle_pkg::CMD_REMOVE_MIN) begin
                removed_out_next = best_reg;
            end
            count_out_next   = PW'(len_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LW'(CAPACITY);
            ptr_reg <= '0;
            pv_reg  <= 1'b0;
        end else begin
            len_reg <= len_next;
            ptr_reg <= ptr_next;
            pv_reg  <= pv_next;
        end
        op_reg          <= op_next;
        pos_reg         <= pos_next;
        val_reg         <= val_next;
        end_reg         <= end_next;
        q_reg           <= q_next;
        first_reg       <= first_next;
        best_reg        <= best_next;
        at_reg          <= at_next;
        last_reg        <= last_next;
        removed_reg     <= removed_next;
        found_reg       <= found_next;
        hit_reg         <= hit_next;
        ok_out_reg      <= ok_out_next;
        found_out_reg   <= found_out_next;
        removed_out_reg <= removed_out_next;
        count_out_reg   <= count_out_next;
    end

    assign m_ok             = ok_out_reg;
    assign m_found_position = found_out_reg;
    assign m_removed_value  = removed_out_reg;
    assign m_list_count     = count_out_reg;

endmodule

`default_nettype wire

>>> hdl/sle_controller.sv
// List engine controller: sequences the initial fill, range check, walk, final write and result.
`timescale 1ns / 1ps
`default_nettype none

module sle_controller (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output sle_pkg::sle_cmd_t         cmd,
    input  wire sle_pkg::sle_status_t status
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   commit;

    assign commit = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd.init_step = (state_reg == ST_INIT);
        cmd.load      = (state_reg == ST_IDLE) && s_valid;
        cmd.check     = (state_reg == ST_CHECK);
        cmd.read_en   = (state_reg == ST_SCAN);
        cmd.fix       = (state_reg == ST_FIX);
        cmd.commit    = commit;
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_INIT: begin
                if (status.init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.scan_needed) begin
                    state_next = ST_SCAN;
                end else if (status.fix_needed) begin
                    state_next = ST_FIX;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = status.fix_needed ? ST_FIX : ST_DONE;
            end
            ST_FIX: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (commit) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> bench/tb_sequential_list_engine.sv
// Self-checking testbench for the sequential list engine: directed table, then random commands.
`timescale 1ns / 1ps
`default_nettype none

module tb_sequential_list_engine;

    import sle_pkg::*;

    localparam int CAPACITY = CAPACITY_DEFAULT;

    // Command codes the block does not decode; they must be answered and leave the list alone.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    localparam int RANDOM_PASSES    = 2;
    localparam int ITEMS_PER_PHASE  = 244;
    localparam int DIRECTED_ROWS    = 28;

    typedef struct packed {
        logic                     ok;
        logic [POS_W-1:0]         found;
        logic signed [DATA_W-1:0] removed;
        logic [POS_W-1:0]         count;
    } list_reply_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        logic [POS_W-1:0]         reps;
        logic                     typed;
        list_reply_t              reply;
    } directed_row_t;

    // Rows marked typed carry their answer; the rest are answered by the list shadow.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{CMD_LOCATE,      6'd0,  32'sd1,   6'd1,  1'b1, '{1'b1, 6'd1,  32'sd0,   6'd32}},
        '{CMD_LOCATE,      6'd0,  32'sd32,  6'd1,  1'b1, '{1'b1, 6'd32, 32'sd0,   6'd32}},
        '{CMD_LOCATE,      6'd0,  32'sd0,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd32}},
        '{CMD_INSERT,      6'd1,  32'sd77,  6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd32}},
        '{CMD_DELETE,      6'd0,  32'sd0,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd32}},
        '{CMD_DELETE,      6'd33, 32'sd0,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd32}},
        '{CMD_UPDATE,      6'd63, 32'sd0,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd32}},
        '{CMD_UPDATE,      6'd32, WORD_MAX, 6'd1,  1'b1, '{1'b1, 6'd0,  32'sd0,   6'd32}},
        '{CMD_UPDATE,      6'd1,  WORD_MIN, 6'd1,  1'b1, '{1'b1, 6'd0,  32'sd0,   6'd32}},
        '{CMD_REMOVE_MIN,  6'd0,  32'sd0,   6'd1,  1'b1, '{1'b1, 6'd0,  WORD_MIN, 6'd31}},
        '{CMD_DELETE,      6'd1,  32'sd0,   6'd1,  1'b1, '{1'b1, 6'd0,  WORD_MAX, 6'd30}},
        '{CMD_SPARE_FIRST, 6'd1,  32'sd5,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd30}},
        '{CMD_SPARE_LAST,  6'd63, -32'sd1,  6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd30}},
        '{CMD_INSERT,      6'd32, 32'sd9,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd30}},
        '{CMD_INSERT,      6'd31, -32'sd1,  6'd1,  1'b0, '0},
        '{CMD_INSERT,      6'd1,  32'sd5,   6'd1,  1'b0, '0},
        '{CMD_LOCATE,      6'd0,  32'sd5,   6'd1,  1'b0, '0},
        '{CMD_UPDATE,      6'd3,  32'sd2,   6'd1,  1'b0, '0},
        '{CMD_REMOVE_MIN,  6'd0,  32'sd0,   6'd1,  1'b0, '0},
        '{CMD_REMOVE_MIN,  6'd0,  32'sd0,   6'd1,  1'b0, '0},
        '{CMD_DELETE,      6'd1,  32'sd0,   6'd30, 1'b0, '0},
        '{CMD_REMOVE_MIN,  6'd0,  32'sd0,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd0}},
        '{CMD_DELETE,      6'd1,  32'sd0,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd0}},
        '{CMD_UPDATE,      6'd1,  32'sd3,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd0}},
        '{CMD_LOCATE,      6'd0,  32'sd0,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd0}},
        '{CMD_INSERT,      6'd2,  32'sd4,   6'd1,  1'b1, '{1'b0, 6'd0,  32'sd0,   6'd0}},
        '{CMD_INSERT,      6'd1,  WORD_MIN, 6'd1,  1'b1, '{1'b1, 6'd0,  32'sd0,   6'd1}},
        '{CMD_DELETE,      6'd1,  32'sd0,   6'd1,  1'b1, '{1'b1, 6'd0,  WORD_MIN, 6'd0}}
    };

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_command;
    logic [POS_W-1:0]         s_position;
    logic signed [DATA_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_ok;
    logic [POS_W-1:0]         m_found_position;
    logic signed [DATA_W-1:0] m_removed_value;
    logic [POS_W-1:0]         m_list_count;

    // Shadow copy of the list, advanced as each command is issued.
    logic signed [DATA_W-1:0] shadow_list [CAPACITY];
    int                       shadow_len;

    list_reply_t pending_replies [$];
    int          beats_issued;
    int          beats_accepted;
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    sequential_list_engine #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ok            (m_ok),
        .m_found_position(m_found_position),
        .m_removed_value (m_removed_value),
        .m_list_count    (m_list_count)
    );

    always #10 aclk = ~aclk;

    function automatic list_reply_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic signed [DATA_W-1:0] val);
        list_reply_t              r;
        int                       p;
        int                       k;
        int                       at;
        logic signed [DATA_W-1:0] best;
        r = '0;
        p = int'(pos);
        case (cmd)
            CMD_INSERT: begin
                if (p >= 1 && p <= shadow_len + 1 && shadow_len < CAPACITY) begin
                    for (k = shadow_len; k >= p; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[p-1] = val;
                    shadow_len++;
                    r.ok = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (p >= 1 && p <= shadow_len) begin
                    r.removed = shadow_list[p-1];
                    for (k = p; k < shadow_len; k++)
                        shadow_list[k-1] = shadow_list[k];
                    shadow_len--;
                    r.ok = 1'b1;
                end
            end
            CMD_UPDATE: begin
                if (p >= 1 && p <= shadow_len) begin
                    shadow_list[p-1] = val;
                    r.ok = 1'b1;
                end
            end
            CMD_LOCATE: begin
                for (k = shadow_len - 1; k >= 0; k--) begin
                    if (shadow_list[k] == val) begin
                        r.found = POS_W'(k + 1);
                        r.ok    = 1'b1;
                    end
                end
            end
            CMD_REMOVE_MIN: begin
                if (shadow_len >= 1) begin
                    best = shadow_list[0];
                    at   = 0;
                    // Strict less-than keeps the first of several equal minima.
                    for (k = 1; k < shadow_len; k++) begin
                        if (shadow_list[k] < best) begin
                            best = shadow_list[k];
                            at   = k;
                        end
                    end
                    r.removed       = best;
                    shadow_list[at] = shadow_list[shadow_len-1];
                    shadow_len--;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = POS_W'(shadow_len);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic push_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val, input bit typed,
                                input list_reply_t typed_reply);
        list_reply_t predicted;
        int          target;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        predicted = apply_list_command(cmd, pos, val);
        pending_replies.push_back(typed ? typed_reply : predicted);
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_position <= pos;
        s_value    <= val;
        beats_issued++;
        target = beats_issued;
        do
            @(negedge aclk);
        while (beats_accepted < target);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (s_valid && s_ready)
            beats_accepted++;
    end

    always @(posedge aclk) begin
        list_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: result beat with nothing outstanding, ok %b count %0d",
                         $time, m_ok, m_list_count);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                check_field("ok", DATA_W'(want.ok), DATA_W'(m_ok));
                check_field("found_position", DATA_W'(want.found), DATA_W'(m_found_position));
                check_field("removed_value", want.removed, m_removed_value);
                check_field("list_count", DATA_W'(want.count), DATA_W'(m_list_count));
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #20_000_000;
        $display("sequential_list_engine verification failed");
        $finish;
    end

    initial begin
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int                       r;
        int                       hi;

        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_command      = CMD_INSERT;
        s_position     = '0;
        s_value        = '0;
        m_ready        = 1'b0;
        beats_issued   = 0;
        beats_accepted = 0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < CAPACITY; i++)
            shadow_list[i] = DATA_W'(i + 1);
        shadow_len = CAPACITY;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            for (int n = 0; n < int'(DIRECTED[row].reps); n++)
                push_command(DIRECTED[row].cmd, DIRECTED[row].pos, DIRECTED[row].val,
                             DIRECTED[row].typed, DIRECTED[row].reply);
        end
        wait_for_drain();

        for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
            for (int phase = 0; phase < 4; phase++) begin
                case (phase)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                    default: begin send_idle_pct = 36; recv_stall_pct = 36; end
                endcase
                for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                    r = $urandom_range(99);
                    if (r < 30)
                        cmd = CMD_INSERT;
                    else if (r < 50)
                        cmd = CMD_DELETE;
                    else if (r < 64)
                        cmd = CMD_UPDATE;
                    else if (r < 84)
                        cmd = CMD_LOCATE;
                    else if (r < 95)
                        cmd = CMD_REMOVE_MIN;
                    else
                        cmd = CMD_SPARE_FIRST +
                              CMD_W'($urandom_range(CMD_SPARE_LAST - CMD_SPARE_FIRST));

                    // Mostly legal positions so the list keeps moving; some anywhere in range.
                    hi = (cmd == CMD_INSERT) ? shadow_len + 1 : shadow_len;
                    if (hi < 1)
                        hi = 1;
                    if ($urandom_range(99) < 85)
                        pos = POS_W'($urandom_range(hi, 1));
                    else
                        pos = POS_W'($urandom_range(63, 0));

                    // Small values give ties and locate hits; full words reach every bit.
                    r = $urandom_range(99);
                    if (cmd == CMD_LOCATE && shadow_len > 0 && r < 50)
                        val = shadow_list[$urandom_range(shadow_len - 1)];
                    else if (r < 60)
                        val = $signed(DATA_W'($urandom_range(16))) - 32'sd8;
                    else if (r < 65)
                        val = ($urandom_range(1)) ? WORD_MIN : WORD_MAX;
                    else
                        val = $signed($urandom);

                    push_command(cmd, pos, val, 1'b0, '0);
                end
                // The sender holds off here until every outstanding result is back.
                wait_for_drain();
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_for_drain();
        repeat (CAPACITY + 10) @(negedge aclk);

        if (mismatch_count == 0)
            $display("sequential_list_engine verification clean");
        else
            $display("sequential_list_engine verification failed");
        $finish;
    end

endmodule

`default_nettype wire
